// ===== sv/skl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline allocator package
// Shared types, codes and widths of the skyline rectangle allocator.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;

	localparam int DATA_W   = 16;
	localparam int SPAN_W   = 17;
	localparam int LEVEL_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int SEG_W    = LEVEL_W + SPAN_W;

	localparam logic [DATA_W-1:0] BIN_RESET = 16'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_QUERY = 2'd1,
		OP_PLACE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_Q_ACC,
		ST_Q_EVAL,
		ST_P_LEFT,
		ST_P_MID,
		ST_P_RIGHT,
		ST_P_FLUSH,
		ST_C_RD,
		ST_C_WR
	} state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [SPAN_W-1:0]  span;
	} seg_t;

	typedef struct packed {
		logic               init;
		logic               flush;
		logic               valid;
		logic [SPAN_W-1:0]  span;
		logic [LEVEL_W-1:0] level;
	} emit_req_t;

endpackage
`default_nettype wire

// ===== sv/skl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skl_ram #(
	parameter int WIDTH = skl_pkg::SEG_W,
	parameter int DEPTH = skl_pkg::MAX_SEGMENTS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/skl_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline segment emitter
// Appends pieces to the rebuild list, merging a piece into the previous one
// when their levels match. The last piece is held in a register until it
// can no longer grow.
// ----------------------------------------------------------------------------
module skl_emit #(
	parameter int MAX_SEGMENTS = skl_pkg::MAX_SEGMENTS_DEF,
	localparam int IW = $clog2(MAX_SEGMENTS),
	localparam int CW = $clog2(MAX_SEGMENTS + 2)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire skl_pkg::emit_req_t req,
	output logic [CW-1:0]           cnt,
	output logic                    tmp_we,
	output logic [IW-1:0]           tmp_waddr,
	output skl_pkg::seg_t           tmp_wdata
);

	localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_n;
	logic [CW-1:0]  cnt_m1;
	skl_pkg::seg_t  pend_q;
	skl_pkg::seg_t  pend_n;
	logic           can_wr;

	assign cnt_m1 = cnt_q - 1'b1;
	assign can_wr = (cnt_q != '0) && (cnt_q <= MAX_C);

	always_comb begin
		cnt_n     = cnt_q;
		pend_n    = pend_q;
		tmp_we    = 1'b0;
		tmp_waddr = cnt_m1[IW-1:0];
		tmp_wdata = pend_q;
		if (req.init) begin
			cnt_n = '0;
		end else if (req.flush) begin
			tmp_we = can_wr;
		end else if (req.valid && (req.span != '0)) begin
			if ((cnt_q != '0) && (pend_q.level == req.level)) begin
				pend_n.span = pend_q.span + req.span;
			end else begin
				tmp_we       = can_wr;
				pend_n.level = req.level;
				pend_n.span  = req.span;
				if (cnt_q <= MAX_C) begin
					cnt_n = cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_n;
	end

	assign cnt = cnt_q;

endmodule
`default_nettype wire

// ===== sv/skyline_rectangle_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline rectangle allocator
// Keeps a bottom-left skyline in a segment RAM, answers best-position queries
// and places rectangles by rebuilding the segment list through a second RAM.
//
// Channel   Signals                                         Direction
// command   start, busy, op, rect_width, rect_height,       in / busy out
//           place_x, place_y
// result    done, status, found_x, found_y                   out, one cycle
// config    cfg_we, cfg_index, cfg_wdata                     in
//
// Clear, unused opcodes and rejected commands answer in the following cycle.
// A query reads the segments of every window in turn through the single read
// port of the segment RAM and evaluates each start segment after its window.
// A place rebuilds the segment list in the second RAM and, unless the new
// list overflows, copies it back. Reset leaves one floor segment of width
// 1024 and needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module skyline_rectangle_allocator #(
	parameter int MAX_SEGMENTS = skl_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     op,
	input  wire logic [skl_pkg::DATA_W-1:0]     rect_width,
	input  wire logic [skl_pkg::DATA_W-1:0]     rect_height,
	input  wire logic [skl_pkg::DATA_W-1:0]     place_x,
	input  wire logic [skl_pkg::DATA_W-1:0]     place_y,
	input  wire logic                           cfg_we,
	input  wire logic [skl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [skl_pkg::DATA_W-1:0]     cfg_wdata,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [skl_pkg::DATA_W-1:0]          found_x,
	output logic [skl_pkg::DATA_W-1:0]          found_y
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 2);
	localparam int DW = skl_pkg::DATA_W;
	localparam int SW = skl_pkg::SPAN_W;
	localparam int LW = skl_pkg::LEVEL_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

	skl_pkg::state_t state_q, state_n;

	logic [DW-1:0] bw_q, bh_q;
	logic [SW-1:0] extent_q;
	logic          floor_q;
	logic [CW-1:0] count_q;

	logic               done_q;
	skl_pkg::status_t   status_q;
	logic [DW-1:0]      fx_q, fy_q;

	logic [DW-1:0] rw_q, rh_q, px_q, py_q;
	logic [SW-1:0] xe_q;
	logic [CW-1:0] i_q, j_q;
	logic [SW-1:0] acc_q, si_q, span_i_q;
	logic [LW-1:0] top_q, by_q;
	logic [DW-1:0] bx_q;
	logic          found_q;
	logic [SW-1:0] seg_s_q, seg_e_q;
	logic [LW-1:0] seg_l_q;
	logic          ins_q;
	logic          rd_floor_s1;

	logic                     m_we, m_re, t_re, t_we;
	logic [IW-1:0]            m_waddr, m_raddr, t_raddr, t_waddr;
	logic [skl_pkg::SEG_W-1:0] m_rdata, t_rdata;
	skl_pkg::seg_t            m_wdata, t_wdata, seg;
	skl_pkg::emit_req_t       ereq;
	logic [CW-1:0]            ecnt;

	logic          accept, outside, imm_fire, result_fire;
	skl_pkg::op_t  op_in;
	logic [SW-1:0] in_xe, in_top, x17, rw17, p_e, mid_rs;
	logic [CW-1:0] nxt_idx, j_nxt;
	logic [LW-1:0] q_top_n;
	logic [SW-1:0] q_acc_n;
	logic          q_more, q_fit, q_upd, q_last, q_found_n;
	logic [DW-1:0] q_bx_n;
	logic [LW-1:0] q_by_n;
	logic          p_more, c_more, full, mid_valid;
	logic [LW-1:0] place_level;

	assign busy   = (state_q != skl_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign op_in  = skl_pkg::op_t'(op);

	assign in_xe   = {1'b0, place_x} + {1'b0, rect_width};
	assign in_top  = {1'b0, place_y} + {1'b0, rect_height};
	assign outside = (rect_width == '0) || (in_xe > {1'b0, bw_q}) || (in_xe > extent_q)
		|| (in_top > {1'b0, bh_q});

	assign imm_fire = accept && ((op_in == skl_pkg::OP_CLEAR) || (op_in == skl_pkg::OP_NONE)
		|| ((op_in == skl_pkg::OP_QUERY) && (rect_width == '0))
		|| ((op_in == skl_pkg::OP_PLACE) && outside));

	always_comb begin
		seg = skl_pkg::seg_t'(m_rdata);
		if (rd_floor_s1) begin
			seg.level = '0;
			seg.span  = extent_q;
		end
	end

	assign x17     = {1'b0, px_q};
	assign rw17    = {1'b0, rw_q};
	assign nxt_idx = i_q + 1'b1;
	assign j_nxt   = j_q + 1'b1;

	assign q_top_n   = (seg.level > top_q) ? seg.level : top_q;
	assign q_acc_n   = acc_q + seg.span;
	assign q_more    = (j_nxt < count_q) && (q_acc_n < rw17);
	assign q_fit     = ({1'b0, top_q} + {1'b0, rh_q}) <= {1'b0, bh_q};
	assign q_upd     = (acc_q >= rw17) && q_fit && (!found_q || (top_q < by_q));
	assign q_last    = (acc_q < rw17) || !(nxt_idx < count_q);
	assign q_found_n = q_upd || found_q;
	assign q_bx_n    = q_upd ? si_q[DW-1:0] : bx_q;
	assign q_by_n    = q_upd ? top_q : by_q;

	assign p_e         = seg_s_q + seg.span;
	assign p_more      = nxt_idx < count_q;
	assign mid_valid   = !ins_q && (seg_e_q > x17);
	assign mid_rs      = (seg_s_q > xe_q) ? seg_s_q : xe_q;
	assign place_level = py_q + rh_q;
	assign full        = ecnt > MAX_C;
	assign c_more      = nxt_idx < ecnt;

	assign result_fire = ((state_q == skl_pkg::ST_IDLE) && imm_fire)
		|| ((state_q == skl_pkg::ST_Q_EVAL) && q_last)
		|| ((state_q == skl_pkg::ST_P_FLUSH) && full)
		|| ((state_q == skl_pkg::ST_C_WR) && !c_more);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			skl_pkg::ST_IDLE: begin
				if (accept && !imm_fire) begin
					state_n = (op_in == skl_pkg::OP_QUERY) ? skl_pkg::ST_Q_ACC
						: skl_pkg::ST_P_LEFT;
				end
			end
			skl_pkg::ST_Q_ACC: begin
				if (!q_more) begin
					state_n = skl_pkg::ST_Q_EVAL;
				end
			end
			skl_pkg::ST_Q_EVAL: begin
				state_n = q_last ? skl_pkg::ST_IDLE : skl_pkg::ST_Q_ACC;
			end
			skl_pkg::ST_P_LEFT:  state_n = skl_pkg::ST_P_MID;
			skl_pkg::ST_P_MID:   state_n = skl_pkg::ST_P_RIGHT;
			skl_pkg::ST_P_RIGHT: begin
				state_n = p_more ? skl_pkg::ST_P_LEFT : skl_pkg::ST_P_FLUSH;
			end
			skl_pkg::ST_P_FLUSH: begin
				state_n = full ? skl_pkg::ST_IDLE : skl_pkg::ST_C_RD;
			end
			skl_pkg::ST_C_RD: state_n = skl_pkg::ST_C_WR;
			skl_pkg::ST_C_WR: begin
				state_n = c_more ? skl_pkg::ST_C_RD : skl_pkg::ST_IDLE;
			end
			default: state_n = skl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		m_re       = 1'b0;
		m_raddr    = '0;
		m_we       = 1'b0;
		m_waddr    = i_q[IW-1:0];
		m_wdata    = skl_pkg::seg_t'(t_rdata);
		t_re       = 1'b0;
		t_raddr    = i_q[IW-1:0];
		ereq.init  = 1'b0;
		ereq.flush = 1'b0;
		ereq.valid = 1'b0;
		ereq.span  = '0;
		ereq.level = '0;
		unique case (state_q)
			skl_pkg::ST_IDLE: begin
				if (accept && !imm_fire) begin
					m_re      = 1'b1;
					ereq.init = 1'b1;
				end
			end
			skl_pkg::ST_Q_ACC: begin
				m_re    = q_more;
				m_raddr = j_nxt[IW-1:0];
			end
			skl_pkg::ST_Q_EVAL: begin
				m_re    = !q_last;
				m_raddr = nxt_idx[IW-1:0];
			end
			skl_pkg::ST_P_LEFT: begin
				ereq.valid = seg_s_q < x17;
				ereq.span  = ((p_e < x17) ? p_e : x17) - seg_s_q;
				ereq.level = seg.level;
			end
			skl_pkg::ST_P_MID: begin
				ereq.valid = mid_valid;
				ereq.span  = rw17;
				ereq.level = place_level;
			end
			skl_pkg::ST_P_RIGHT: begin
				ereq.valid = seg_e_q > xe_q;
				ereq.span  = seg_e_q - mid_rs;
				ereq.level = seg_l_q;
				m_re       = p_more;
				m_raddr    = nxt_idx[IW-1:0];
			end
			skl_pkg::ST_P_FLUSH: ereq.flush = 1'b1;
			skl_pkg::ST_C_RD:    t_re = 1'b1;
			skl_pkg::ST_C_WR:    m_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= skl_pkg::ST_IDLE;
			bw_q     <= skl_pkg::BIN_RESET;
			bh_q     <= skl_pkg::BIN_RESET;
			extent_q <= {1'b0, skl_pkg::BIN_RESET};
			floor_q  <= 1'b1;
			count_q  <= CW'(1);
			done_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= result_fire;
			if (cfg_we) begin
				unique case (cfg_index)
					skl_pkg::REG_BIN_WIDTH:  bw_q <= cfg_wdata;
					skl_pkg::REG_BIN_HEIGHT: bh_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if ((state_q == skl_pkg::ST_IDLE) && accept && (op_in == skl_pkg::OP_CLEAR)) begin
				floor_q  <= 1'b1;
				extent_q <= {1'b0, bw_q};
				count_q  <= CW'(1);
			end
			if ((state_q == skl_pkg::ST_C_WR) && !c_more) begin
				floor_q <= 1'b0;
				count_q <= ecnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_re) begin
			rd_floor_s1 <= floor_q && (m_raddr == '0);
		end
		unique case (state_q)
			skl_pkg::ST_IDLE: begin
				if (accept) begin
					rw_q     <= rect_width;
					rh_q     <= rect_height;
					px_q     <= place_x;
					py_q     <= place_y;
					xe_q     <= in_xe;
					i_q      <= '0;
					j_q      <= '0;
					acc_q    <= '0;
					top_q    <= '0;
					si_q     <= '0;
					found_q  <= 1'b0;
					seg_s_q  <= '0;
					ins_q    <= 1'b0;
					fx_q     <= '0;
					fy_q     <= '0;
					if ((op_in == skl_pkg::OP_QUERY) && (rect_width == '0)) begin
						status_q <= skl_pkg::STAT_NOFIT;
					end else if ((op_in == skl_pkg::OP_PLACE) && outside) begin
						status_q <= skl_pkg::STAT_OUTSIDE;
					end else begin
						status_q <= skl_pkg::STAT_OK;
					end
				end
			end
			skl_pkg::ST_Q_ACC: begin
				top_q <= q_top_n;
				acc_q <= q_acc_n;
				if (j_q == i_q) begin
					span_i_q <= seg.span;
				end
				if (q_more) begin
					j_q <= j_nxt;
				end
			end
			skl_pkg::ST_Q_EVAL: begin
				found_q <= q_found_n;
				bx_q    <= q_bx_n;
				by_q    <= q_by_n;
				if (q_last) begin
					status_q <= q_found_n ? skl_pkg::STAT_OK : skl_pkg::STAT_NOFIT;
					fx_q     <= q_found_n ? q_bx_n : '0;
					fy_q     <= q_found_n ? q_by_n : '0;
				end else begin
					i_q   <= nxt_idx;
					j_q   <= nxt_idx;
					acc_q <= '0;
					top_q <= '0;
					si_q  <= si_q + span_i_q;
				end
			end
			skl_pkg::ST_P_LEFT: begin
				seg_e_q <= p_e;
				seg_l_q <= seg.level;
			end
			skl_pkg::ST_P_MID: begin
				if (mid_valid) begin
					ins_q <= 1'b1;
				end
			end
			skl_pkg::ST_P_RIGHT: begin
				if (p_more) begin
					i_q     <= nxt_idx;
					seg_s_q <= seg_e_q;
				end
			end
			skl_pkg::ST_P_FLUSH: begin
				i_q <= '0;
				if (full) begin
					status_q <= skl_pkg::STAT_FULL;
				end
			end
			skl_pkg::ST_C_RD: begin
			end
			skl_pkg::ST_C_WR: begin
				if (c_more) begin
					i_q <= nxt_idx;
				end else begin
					status_q <= skl_pkg::STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	skl_ram #(
		.WIDTH (skl_pkg::SEG_W),
		.DEPTH (MAX_SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	skl_ram #(
		.WIDTH (skl_pkg::SEG_W),
		.DEPTH (MAX_SEGMENTS)
	) u_tmp_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	skl_emit #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ereq),
		.cnt       (ecnt),
		.tmp_we    (t_we),
		.tmp_waddr (t_waddr),
		.tmp_wdata (t_wdata)
	);

	assign done    = done_q;
	assign status  = status_q;
	assign found_x = fx_q;
	assign found_y = fy_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == skl_pkg::ST_IDLE))
		else $error("result strobe outside idle");

	a_imm_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((op_in == skl_pkg::OP_CLEAR) || (op_in == skl_pkg::OP_NONE))) |=> done_q)
		else $error("clear transaction gave no result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= MAX_C))
		else $error("segment count out of range");

	a_floor_single: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q |-> (count_q == CW'(1)))
		else $error("floor flag with several segments");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != skl_pkg::STAT_OK)) |-> ((fx_q == '0) && (fy_q == '0)))
		else $error("position reported on failed transaction");

endmodule
`default_nettype wire

// ===== test/skyline_rectangle_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Skyline rectangle allocator testbench
// Drives clear, query, place and unused commands in random bursts through
// several bin sizes. A scoreboard predicts every answer from its own copy of
// the skyline and checks each result transaction against the oldest one.
// ----------------------------------------------------------------------------
module skyline_rectangle_allocator_tb;

	localparam int NSEG = skl_pkg::MAX_SEGMENTS_DEF;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		skl_pkg::status_t st;
		logic [15:0]      fx;
		logic [15:0]      fy;
	} answer_t;

	class skyline_scoreboard;
		int unsigned seg_x[NSEG], seg_lv[NSEG], seg_w[NSEG];
		int unsigned nseg;
		int unsigned tx[NSEG+2], tl[NSEG+2], tw[NSEG+2];
		int unsigned tn;
		int unsigned bw, bh;
		answer_t     owed[$];
		int          errors;

		function new();
			bw = 1024;
			bh = 1024;
			errors = 0;
			lay_floor();
		endfunction

		function void lay_floor();
			seg_x[0] = 0;
			seg_lv[0] = 0;
			seg_w[0] = bw;
			nseg = 1;
		endfunction

		function void set_reg(logic [skl_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
			if (idx == skl_pkg::REG_BIN_WIDTH) bw = val;
			else bh = val;
		endfunction

		function int unsigned extent();
			return seg_x[nseg-1] + seg_w[nseg-1];
		endfunction

		function skl_pkg::status_t find_spot(int unsigned rw, int unsigned rh,
				output int unsigned fx, output int unsigned fy);
			int unsigned acc, top, j;
			bit found;
			found = 0;
			fx = 0;
			fy = 0;
			if (rw == 0) return skl_pkg::STAT_NOFIT;
			for (int unsigned i = 0; i < nseg; i++) begin
				acc = 0;
				top = 0;
				for (j = i; j < nseg && acc < rw; j++) begin
					if (seg_lv[j] > top) top = seg_lv[j];
					acc += seg_w[j];
				end
				if (acc < rw) break;
				if (top + rh <= bh && (!found || top < fy)) begin
					found = 1;
					fy = top;
					fx = seg_x[i];
				end
			end
			if (!found) begin
				fx = 0;
				fy = 0;
				return skl_pkg::STAT_NOFIT;
			end
			return skl_pkg::STAT_OK;
		endfunction

		function void add_piece(int unsigned s, int unsigned w, int unsigned l);
			if (w == 0) return;
			if (tn > 0 && tl[tn-1] == l) begin
				tw[tn-1] += w;
				return;
			end
			if (tn >= NSEG + 2) return;
			tx[tn] = s;
			tw[tn] = w;
			tl[tn] = l;
			tn++;
		endfunction

		function skl_pkg::status_t put_rect(int unsigned x, int unsigned y,
				int unsigned rw, int unsigned rh);
			int unsigned xe, s, e, l, rs;
			bit laid;
			xe = x + rw;
			laid = 0;
			if (rw == 0 || xe > bw || xe > extent() || y + rh > bh)
				return skl_pkg::STAT_OUTSIDE;
			tn = 0;
			for (int unsigned i = 0; i < nseg; i++) begin
				s = seg_x[i];
				e = s + seg_w[i];
				l = seg_lv[i];
				if (s < x) add_piece(s, (e < x ? e : x) - s, l);
				if (!laid && e > x) begin
					add_piece(x, rw, y + rh);
					laid = 1;
				end
				if (e > xe) begin
					rs = s > xe ? s : xe;
					add_piece(rs, e - rs, l);
				end
			end
			if (tn > NSEG) return skl_pkg::STAT_FULL;
			for (int unsigned i = 0; i < tn; i++) begin
				seg_x[i] = tx[i];
				seg_w[i] = tw[i];
				seg_lv[i] = tl[i];
			end
			nseg = tn;
			return skl_pkg::STAT_OK;
		endfunction

		function void note(skl_pkg::op_t o, int unsigned w, int unsigned h,
				int unsigned x, int unsigned y);
			answer_t a;
			int unsigned fx, fy;
			a.st = skl_pkg::STAT_OK;
			a.fx = '0;
			a.fy = '0;
			unique case (o)
				skl_pkg::OP_CLEAR: lay_floor();
				skl_pkg::OP_QUERY: begin
					a.st = find_spot(w, h, fx, fy);
					a.fx = 16'(fx);
					a.fy = 16'(fy);
				end
				skl_pkg::OP_PLACE: a.st = put_rect(x, y, w, h);
				default: ;
			endcase
			owed = {owed, a};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(logic [1:0] st, logic [15:0] fx, logic [15:0] fy);
			answer_t a;
			if (owed.size() == 0) begin
				report("result transaction with nothing outstanding");
				return;
			end
			a = owed.pop_front();
			if (st !== a.st) report($sformatf("status %0d, want %0d", st, a.st));
			if (fx !== a.fx) report($sformatf("found_x %0d, want %0d", fx, a.fx));
			if (fy !== a.fy) report($sformatf("found_y %0d, want %0d", fy, a.fy));
		endtask
	endclass

	logic clk, arst_n, start, busy, cfg_we, done;
	logic [1:0] op, status;
	logic [15:0] rect_width, rect_height, place_x, place_y, cfg_wdata, found_x, found_y;
	logic [skl_pkg::CFG_IDX_W-1:0] cfg_index;
	skyline_scoreboard sb;
	int burst_left;
	int cycles;

	skyline_rectangle_allocator dut (
		.clk, .arst_n, .start, .busy, .op, .rect_width, .rect_height, .place_x,
		.place_y, .cfg_we, .cfg_index, .cfg_wdata, .done, .status, .found_x, .found_y
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check(status, found_x, found_y);
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task send(skl_pkg::op_t o, int unsigned w, int unsigned h, int unsigned x,
			int unsigned y);
		int unsigned wm, hm, xm, ym;
		wm = w & 32'hFFFF;
		hm = h & 32'hFFFF;
		xm = x & 32'hFFFF;
		ym = y & 32'hFFFF;
		if (burst_left <= 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		start = 1'b1;
		op = o;
		rect_width = 16'(w);
		rect_height = 16'(h);
		place_x = 16'(x);
		place_y = 16'(y);
		do @(posedge clk); while (busy);
		sb.note(o, wm, hm, xm, ym);
		@(negedge clk);
		burst_left--;
	endtask

	task settle();
		start = 1'b0;
		do @(negedge clk); while (sb.owed.size() != 0 || busy);
	endtask

	task write_reg(logic [skl_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = 16'(val);
		sb.set_reg(idx, val & 32'hFFFF);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task random_item();
		int unsigned k, w, h, fx, fy;
		k = $urandom_range(0, 99);
		w = $urandom_range(1, sb.bw < 64 ? sb.bw : 64);
		h = $urandom_range(1, sb.bh / 4 + 1);
		if (k < 35) begin
			send(skl_pkg::OP_QUERY, w, h, 0, 0);
		end else if (k < 65) begin
			if (sb.find_spot(w, h, fx, fy) == skl_pkg::STAT_OK)
				send(skl_pkg::OP_PLACE, w, h, fx, fy);
			else send(skl_pkg::OP_QUERY, w, h, 0, 0);
		end else if (k < 82) begin
			send(skl_pkg::OP_PLACE, $urandom_range(1, 4), h,
				$urandom_range(0, sb.extent() > 0 ? sb.extent() - 1 : 0),
				$urandom_range(0, sb.bh / 2));
		end else if (k < 85) begin
			send(skl_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
		end else if (k < 87) begin
			send(skl_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
		end else begin
			send(skl_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
				$urandom);
		end
	endtask

	initial begin
		int unsigned pw[7], ph[7];
		bit pc[7];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		op = skl_pkg::OP_CLEAR;
		rect_width = '0;
		rect_height = '0;
		place_x = '0;
		place_y = '0;
		cfg_we = 1'b0;
		cfg_index = skl_pkg::REG_BIN_WIDTH;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(skl_pkg::OP_NONE, 65535, 65535, 65535, 65535);
		send(skl_pkg::OP_QUERY, 0, 1, 0, 0);
		send(skl_pkg::OP_QUERY, 65535, 1, 0, 0);
		send(skl_pkg::OP_QUERY, 1, 65535, 0, 0);
		send(skl_pkg::OP_QUERY, 1, 1, 0, 0);
		send(skl_pkg::OP_PLACE, 0, 1, 0, 0);
		send(skl_pkg::OP_PLACE, 1, 1, 65535, 0);
		send(skl_pkg::OP_PLACE, 1, 1, 0, 65535);
		send(skl_pkg::OP_PLACE, 10, 10, 0, 0);
		send(skl_pkg::OP_PLACE, 5, 20, 100, 500);
		send(skl_pkg::OP_PLACE, 5, 20, 102, 0);
		send(skl_pkg::OP_QUERY, 1024, 1, 0, 0);
		send(skl_pkg::OP_QUERY, 8, 3, 0, 0);
		send(skl_pkg::OP_PLACE, 1024, 1024, 0, 0);
		send(skl_pkg::OP_QUERY, 1, 1, 0, 0);
		send(skl_pkg::OP_CLEAR, 0, 0, 0, 0);
		settle();
		write_reg(skl_pkg::REG_BIN_WIDTH, 65535);
		write_reg(skl_pkg::REG_BIN_HEIGHT, 65535);
		send(skl_pkg::OP_PLACE, 65535, 1, 0, 0);
		send(skl_pkg::OP_QUERY, 2000, 1, 0, 0);
		send(skl_pkg::OP_CLEAR, 0, 0, 0, 0);
		send(skl_pkg::OP_PLACE, 65535, 65535, 0, 0);
		send(skl_pkg::OP_PLACE, 65535, 1, 0, 65535);
		send(skl_pkg::OP_QUERY, 65535, 65535, 0, 0);

		pw = '{1024, 200, 65535, 65535, 1, 40, 0};
		ph = '{1024, 300, 65535, 65535, 1, 65535, 0};
		pc = '{1, 1, 0, 1, 1, 1, 1};
		pw[6] = $urandom_range(1, 600);
		ph[6] = $urandom_range(1, 65535);
		for (int p = 0; p < 7; p++) begin
			settle();
			write_reg(skl_pkg::REG_BIN_WIDTH, pw[p]);
			write_reg(skl_pkg::REG_BIN_HEIGHT, ph[p]);
			if (pc[p]) send(skl_pkg::OP_CLEAR, 0, 0, 0, 0);
			repeat (170) random_item();
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/skl_pkg.sv
sv/skl_ram.sv
sv/skl_emit.sv
sv/skyline_rectangle_allocator.sv
test/skyline_rectangle_allocator_tb.sv
